FILE: src/nstid_pkg.sv
// nstid_pkg: shared constants and types for node_scan_and_transfer_id_table_unit
// no dependencies

package nstid_pkg;

   localparam int TableEntries = 16;
   localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
   localparam int CntW = $clog2(TableEntries + 1);

   localparam int NodeW = 16;
   localparam int TidW = 64;
   localparam int OpW = 3;
   localparam int UsedW = 5;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 16;

   localparam logic [NodeW-1:0] FirstNodeReset = 16'd0;
   localparam logic [NodeW-1:0] LastNodeReset = 16'd127;

   localparam logic [CsrIdxW-1:0] CsrFirstNode = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrLastNode = 2'd1;

   localparam logic [OpW-1:0] OpTakeNext = 3'd0;
   localparam logic [OpW-1:0] OpSetPending = 3'd1;
   localparam logic [OpW-1:0] OpClearPending = 3'd2;
   localparam logic [OpW-1:0] OpNextTid = 3'd3;
   localparam logic [OpW-1:0] OpRestart = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDID,
      ST_CMPID,
      ST_RDCNT,
      ST_INC,
      ST_DONE
   } state_type;

endpackage

FILE: src/node_scan_and_transfer_id_table_unit.sv
// node_scan_and_transfer_id_table_unit: round-robin node scan, pending slot and
// per-node transfer-id counter table with a sequential table search
// depends on nstid_pkg
//
// req channel (req_valid / req_stall, req_opcode, req_node) takes one command per
// transfer; rsp channel (rsp_valid / rsp_stall) returns one status item per
// command, in order. csr_we writes the low bound (index 0) or the high bound
// (index 1) of the scan range; other indexes are ignored. the user must do so
// only while the block is idle; the block does not enforce it. scan, pending
// and restart commands go from the exec state to the done state, which loads
// the result. a transfer-id command walks the allocated entries in turn through
// a single compare unit and a registered memory read.
// req_stall is high from accept until the result is loaded into the output
// register, so no new command is taken before the current result is loaded.
// synchronous reset clears the scan pointer to 0, the pending slot, the entry
// count and rsp_valid, and sets the range to 0..127. the table memory is not
// cleared; only entries below the count are ever read.
// a finished result holds in the output register while rsp_stall is high and
// the block waits with its next result until that one has been taken.

module node_scan_and_transfer_id_table_unit
   import nstid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OpW-1:0]      req_opcode,
   input  logic [NodeW-1:0]    req_node,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [NodeW-1:0]    rsp_node_taken,
   output logic [TidW-1:0]     rsp_transfer_id,
   output logic                rsp_transfer_ok,
   output logic                rsp_pending_valid,
   output logic [NodeW-1:0]    rsp_pending_node,
   output logic [NodeW-1:0]    rsp_scan_next,
   output logic [UsedW-1:0]    rsp_table_used,

   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [NodeW-1:0] first_ff, last_ff;
   logic [NodeW-1:0] scan_ff, scan_in;
   logic [NodeW-1:0] pend_id_ff, pend_id_in;
   logic             pend_flag_ff, pend_flag_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [OpW-1:0]   op_ff;
   logic [NodeW-1:0] node_ff;
   logic [NodeW-1:0] res_taken_ff, res_taken_in;
   logic [TidW-1:0]  res_tid_ff, res_tid_in;
   logic             res_ok_ff, res_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [NodeW-1:0] rsp_node_taken_ff;
   logic [TidW-1:0]  rsp_transfer_id_ff;
   logic             rsp_transfer_ok_ff;
   logic             rsp_pending_valid_ff;
   logic [NodeW-1:0] rsp_pending_node_ff;
   logic [NodeW-1:0] rsp_scan_next_ff;
   logic [UsedW-1:0] rsp_table_used_ff;

   logic [NodeW-1:0] id_mem [TableEntries];
   logic [TidW-1:0]  cnt_mem [TableEntries];
   logic [NodeW-1:0] id_rd_ff;
   logic [TidW-1:0]  cnt_rd_ff;

   logic             id_we, cnt_we;
   logic [IdxW-1:0]  wr_addr;
   logic [TidW-1:0]  cnt_wdata;

   logic             accept, rsp_load, in_range, alloc_go, more_entries;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign in_range = (node_ff >= first_ff) && (node_ff <= last_ff);
   assign more_entries = ((CntW'(idx_ff) + CntW'(1)) < count_ff);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= FirstNodeReset;
         last_ff <= LastNodeReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrFirstNode: first_ff <= csr_wdata;
            CsrLastNode:  last_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff <= FirstNodeReset;
         pend_id_ff <= '0;
         pend_flag_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff <= scan_in;
         pend_id_ff <= pend_id_in;
         pend_flag_ff <= pend_flag_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         node_ff <= req_node;
      end
      idx_ff <= idx_in;
      res_taken_ff <= res_taken_in;
      res_tid_ff <= res_tid_in;
      res_ok_ff <= res_ok_in;
      if (rsp_load) begin
         rsp_node_taken_ff <= res_taken_ff;
         rsp_transfer_id_ff <= res_tid_ff;
         rsp_transfer_ok_ff <= res_ok_ff;
         rsp_pending_valid_ff <= pend_flag_ff;
         rsp_pending_node_ff <= pend_id_ff;
         rsp_scan_next_ff <= scan_ff;
         rsp_table_used_ff <= UsedW'(count_ff);
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[wr_addr] <= node_ff;
      end
      id_rd_ff <= id_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[idx_ff];
   end

   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      pend_id_in = pend_id_ff;
      pend_flag_in = pend_flag_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      res_taken_in = res_taken_ff;
      res_tid_in = res_tid_ff;
      res_ok_in = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_load = 1'b0;
      id_we = 1'b0;
      cnt_we = 1'b0;
      wr_addr = idx_ff;
      cnt_wdata = cnt_rd_ff + TidW'(1);
      alloc_go = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_taken_in = '0;
            res_tid_in = '0;
            res_ok_in = 1'b0;
            idx_in = '0;
            state_in = ST_DONE;
            unique case (op_ff)
               OpTakeNext: begin
                  res_taken_in = scan_ff;
                  scan_in = (scan_ff == last_ff) ? first_ff : scan_ff + NodeW'(1);
               end
               OpSetPending: begin
                  if (in_range && !pend_flag_ff) begin
                     pend_id_in = node_ff;
                     pend_flag_in = 1'b1;
                  end
               end
               OpClearPending: begin
                  pend_id_in = '0;
                  pend_flag_in = 1'b0;
               end
               OpNextTid: begin
                  if (in_range) begin
                     if (count_ff != '0) begin
                        state_in = ST_RDID;
                     end else begin
                        alloc_go = 1'b1;
                     end
                  end
               end
               OpRestart: begin
                  scan_in = first_ff;
                  pend_id_in = '0;
                  pend_flag_in = 1'b0;
               end
               default: ;
            endcase
         end
         ST_RDID: begin
            state_in = ST_CMPID;
         end
         ST_CMPID: begin
            if (id_rd_ff == node_ff) begin
               state_in = ST_RDCNT;
            end else if (more_entries) begin
               idx_in = idx_ff + IdxW'(1);
               state_in = ST_RDID;
            end else begin
               alloc_go = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_RDCNT: begin
            state_in = ST_INC;
         end
         ST_INC: begin
            cnt_we = 1'b1;
            res_tid_in = cnt_rd_ff;
            res_ok_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // new entry at the end of the table, counter starts at zero and leaves at one
      if (alloc_go && (count_ff < CntW'(TableEntries))) begin
         wr_addr = IdxW'(count_ff);
         id_we = 1'b1;
         cnt_we = 1'b1;
         cnt_wdata = TidW'(1);
         res_tid_in = '0;
         res_ok_in = 1'b1;
         count_in = count_ff + CntW'(1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_node_taken = rsp_node_taken_ff;
   assign rsp_transfer_id = rsp_transfer_id_ff;
   assign rsp_transfer_ok = rsp_transfer_ok_ff;
   assign rsp_pending_valid = rsp_pending_valid_ff;
   assign rsp_pending_node = rsp_pending_node_ff;
   assign rsp_scan_next = rsp_scan_next_ff;
   assign rsp_table_used = rsp_table_used_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TableEntries))
      else $error("entry count above table size");

   a_pending_empty_zero: assert property (@(posedge clock) disable iff (reset)
      !pend_flag_ff |-> (pend_id_ff == '0))
      else $error("empty pending slot holds a node");

   a_search_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDID || state_ff == ST_CMPID) |-> (CntW'(idx_ff) < count_ff))
      else $error("search index past allocated entries");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted command not executed");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");
`endif

endmodule
